// ----- rtl/pcme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcme_pkg: shared types and constants of the patch convolution MAC engine
// Field widths, register codes and the per-cycle control bundle for the cells.
// ----------------------------------------------------------------------------
package pcme_pkg;

   localparam int VALUE_W    = 16;   // Q8.8 operand
   localparam int PROD_W     = 32;   // 16 x 16 signed product
   localparam int SUM_W      = 40;   // Q24.16 accumulator
   localparam int WCHAN_W    = 4;
   localparam int WIDX_W     = 8;
   localparam int OUT_CHAN_W = 4;
   localparam int OUT_POS_W  = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int PLEN_W     = 9;
   localparam int NCHAN_W    = 5;
   localparam int PPS_W      = 13;

   localparam logic [PLEN_W-1:0]  RST_PATCH_LEN = 9'd75;
   localparam logic [NCHAN_W-1:0] RST_NUM_CHANS = 5'd16;
   localparam logic [PPS_W-1:0]   RST_PPS       = 13'd576;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATCH_LEN    = 2'd0,
      CSR_NUM_CHANNELS = 2'd1,
      CSR_POSITIONS    = 2'd2
   } csr_index_type;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_ELEM = 1'b1;

   // control broadcast to every cell
   typedef struct packed {
      logic                       rd_en;     // element accepted: fetch weight
      logic                       wr_en;     // weight load accepted
      logic [WCHAN_W-1:0]         wr_chan;
      logic [VALUE_W-1:0]         wr_data;
      logic                       mac_en;    // multiply stage valid
      logic signed [VALUE_W-1:0]  val;       // element for multiply stage
      logic                       acc_en;    // accumulate stage valid
      logic                       capture;   // patch end: move sum to chain
      logic                       shift;     // chain advances one cell
   } cell_ctl_type;

endpackage

// ----- rtl/patch_conv_mac_engine_top.sv -----
`timescale 1ns / 1ps
// The last element of a patch passes the weight fetch, multiply and accumulate stages; then the channel 0 result
// is registered in cell 0. Throughput: weight loads and patch elements are taken one per cycle within a patch.
// At a patch end the input stalls while the patch end passes the MAC pipeline, and then
// while the result chain drains, one result transfer per active channel.
// Reset clears control state, counters, registers to defaults and all accumulators;
// weight memories are undefined until loaded.
// ----------------------------------------------------------------------------
// patch_conv_mac_engine_top: im2col convolution dot-product engine
// Chain of per-channel MAC cells fed by a broadcast element; sums drain along
// the chain toward cell 0, which is the result output register.
// ----------------------------------------------------------------------------
module patch_conv_mac_engine_top
   import pcme_pkg::*;
#(
   parameter int MAX_CHANNELS  = 16,
   parameter int MAX_PATCH     = 256,
   parameter int MAX_POSITIONS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [VALUE_W-1:0]     req_value,
   input  logic [WCHAN_W-1:0]            req_weight_channel,
   input  logic [WIDX_W-1:0]             req_weight_index,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SUM_W-1:0]       rsp_sum,
   output logic [OUT_CHAN_W-1:0]         rsp_channel,
   output logic [OUT_POS_W-1:0]          rsp_position,
   output logic                          rsp_last,
   // configuration writes
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   // element index into each weight memory
   localparam int IDX_W  = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;
   // patch length compare width (must hold MAX_PATCH and the 9-bit register)
   localparam int LW     = (IDX_W + 1 > PLEN_W) ? IDX_W + 1 : PLEN_W;
   // active channel count, 1..MAX_CHANNELS
   localparam int CHC_W  = $clog2(MAX_CHANNELS + 1);
   localparam int CI_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int POS_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int PW     = (POS_W + 1 > PPS_W) ? POS_W + 1 : PPS_W;

   // configuration registers
   logic [PLEN_W-1:0]   patch_len_ff;
   logic [NCHAN_W-1:0]  num_chans_ff;
   logic [PPS_W-1:0]    pps_ff;

   // effective (clamped) settings
   logic [LW-1:0]       len_eff;
   logic [CHC_W-1:0]    chans_eff;
   logic [PW-1:0]       pps_eff;

   // counters
   logic [IDX_W-1:0]    elem_cnt_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [PW-1:0]       pos_nx;
   logic                end_hit;

   // MAC pipeline control
   logic                s1_valid_ff;
   logic                s1_end_ff;
   logic signed [VALUE_W-1:0] s1_val_ff;
   logic [CHC_W-1:0]    s1_chans_ff;
   logic                s2_valid_ff;
   logic                s2_end_ff;
   logic [CHC_W-1:0]    s2_chans_ff;

   // result drain
   logic                drain_ff;
   logic [CI_W-1:0]     ch_cnt_ff;
   logic [CHC_W-1:0]    drain_chans_ff;
   logic [POS_W-1:0]    out_pos_ff;

   logic                req_xfer;
   logic                elem_xfer;
   logic                load_xfer;
   logic                rsp_xfer;
   logic                capture;
   logic                last_rsp;
   cell_ctl_type        ctl;
   logic signed [SUM_W-1:0] chain [MAX_CHANNELS];

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         patch_len_ff <= RST_PATCH_LEN;
         num_chans_ff <= RST_NUM_CHANS;
         pps_ff       <= RST_PPS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATCH_LEN:    patch_len_ff <= csr_wdata[PLEN_W-1:0];
            CSR_NUM_CHANNELS: num_chans_ff <= csr_wdata[NCHAN_W-1:0];
            CSR_POSITIONS:    pps_ff       <= csr_wdata[PPS_W-1:0];
            default: ;        // unmapped index: write dropped
         endcase
      end
   end

   // zero acts as one, values above the build limit act as the limit
   always_comb begin
      if (patch_len_ff == '0) begin
         len_eff = LW'(1);
      end else if (32'(patch_len_ff) > MAX_PATCH) begin
         len_eff = LW'(MAX_PATCH);
      end else begin
         len_eff = LW'(patch_len_ff);
      end

      if (num_chans_ff == '0) begin
         chans_eff = CHC_W'(1);
      end else if (32'(num_chans_ff) > MAX_CHANNELS) begin
         chans_eff = CHC_W'(MAX_CHANNELS);
      end else begin
         chans_eff = CHC_W'(num_chans_ff);
      end

      if (pps_ff == '0) begin
         pps_eff = PW'(1);
      end else if (32'(pps_ff) > MAX_POSITIONS) begin
         pps_eff = PW'(MAX_POSITIONS);
      end else begin
         pps_eff = PW'(pps_ff);
      end
   end

   // ---- input handshake ----
   // Hold off new items from the patch-end element until the chain is drained.
   assign req_ready = !drain_ff && !s1_end_ff && !s2_end_ff;
   assign req_xfer  = req_valid && req_ready;
   assign elem_xfer = req_xfer && (req_kind == KIND_ELEM);
   assign load_xfer = req_xfer && (req_kind == KIND_LOAD)
                      && (32'(req_weight_index) < MAX_PATCH);

   assign end_hit = (LW'(elem_cnt_ff) + LW'(1)) >= len_eff;
   assign pos_nx  = PW'(pos_ff) + PW'(1);

   // ---- element and position counters ----
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_cnt_ff <= '0;
         pos_ff      <= '0;
      end else if (elem_xfer) begin
         if (end_hit) begin
            elem_cnt_ff <= '0;
            pos_ff      <= (pos_nx >= pps_eff) ? '0 : pos_nx[POS_W-1:0];
         end else begin
            elem_cnt_ff <= elem_cnt_ff + IDX_W'(1);
         end
      end
   end

   // position tag of the patch in flight; drain of the previous patch is done
   always_ff @(posedge clock) begin
      if (elem_xfer && end_hit) begin
         out_pos_ff <= pos_ff;
      end
   end

   // ---- MAC pipeline: fetch -> multiply -> accumulate ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_end_ff   <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_end_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= elem_xfer;
         s1_end_ff   <= elem_xfer && end_hit;
         s2_valid_ff <= s1_valid_ff;
         s2_end_ff   <= s1_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_val_ff   <= req_value;
      s1_chans_ff <= chans_eff;
      s2_chans_ff <= s1_chans_ff;
   end

   assign capture = s2_valid_ff && s2_end_ff;

   // ---- result drain along the chain ----
   assign rsp_valid = drain_ff;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign last_rsp  = (CHC_W'(ch_cnt_ff) + CHC_W'(1)) == drain_chans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff  <= 1'b0;
         ch_cnt_ff <= '0;
      end else if (capture) begin
         drain_ff  <= 1'b1;
         ch_cnt_ff <= '0;
      end else if (rsp_xfer) begin
         if (last_rsp) begin
            drain_ff <= 1'b0;
         end
         ch_cnt_ff <= ch_cnt_ff + CI_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         drain_chans_ff <= s2_chans_ff;
      end
   end

   // ---- cell control ----
   always_comb begin
      ctl.rd_en   = elem_xfer;
      ctl.wr_en   = load_xfer;
      ctl.wr_chan = req_weight_channel;
      ctl.wr_data = req_value;
      ctl.mac_en  = s1_valid_ff;
      ctl.val     = s1_val_ff;
      ctl.acc_en  = s2_valid_ff;
      ctl.capture = capture;
      ctl.shift   = rsp_xfer;
   end

   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
      logic signed [SUM_W-1:0] chain_in;
      if (i == MAX_CHANNELS - 1) begin : g_tail
         assign chain_in = '0;
      end else begin : g_link
         assign chain_in = chain[i+1];
      end

      pcme_mac_cell #(
         .CELL_IDX  (i),
         .IDX_W     (IDX_W),
         .MAX_PATCH (MAX_PATCH),
         .CHC_W     (CHC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .rd_addr   (elem_cnt_ff),
         .wr_addr   (IDX_W'(req_weight_index)),
         .chans     (s2_chans_ff),
         .chain_in  (chain_in),
         .chain_out (chain[i])
      );
   end

   // cell 0 holds the result at the head of the chain
   assign rsp_sum      = chain[0];
   assign rsp_channel  = OUT_CHAN_W'(ch_cnt_ff);
   assign rsp_position = OUT_POS_W'(out_pos_ff);
   assign rsp_last     = last_rsp;

`ifndef SYNTHESIS
   // no patch end may be in the MAC pipeline while the chain drains
   a_no_end_during_drain: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (!s1_end_ff && !s2_end_ff))
      else $error("patch end in flight during drain");

   // drain channel counter stays inside the captured channel count
   a_ch_cnt_range: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (CHC_W'(ch_cnt_ff) < drain_chans_ff))
      else $error("drain channel counter out of range");

   // drain starts only from a patch end leaving the accumulate stage
   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      $rose(drain_ff) |-> $past(s2_valid_ff && s2_end_ff))
      else $error("drain started without a patch end");

   // last result transfer ends the drain
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last) |=> !drain_ff)
      else $error("drain continued past last result");
`endif

endmodule

// ----- rtl/pcme_mac_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcme_mac_cell: one output channel of the MAC chain
// Private weight memory, multiply and accumulate stages, one result chain tap.
// ----------------------------------------------------------------------------
module pcme_mac_cell
   import pcme_pkg::*;
#(
   parameter int CELL_IDX  = 0,
   parameter int IDX_W     = 8,
   parameter int MAX_PATCH = 256,
   parameter int CHC_W     = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  logic [IDX_W-1:0]        rd_addr,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [CHC_W-1:0]        chans,
   input  logic signed [SUM_W-1:0] chain_in,
   output logic signed [SUM_W-1:0] chain_out
);

   logic [VALUE_W-1:0]         mem [MAX_PATCH];
   logic signed [VALUE_W-1:0]  w_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SUM_W-1:0]    acc_ff;
   logic signed [SUM_W-1:0]    acc_in;
   logic signed [SUM_W-1:0]    chain_ff;
   logic                       wr_hit;
   logic                       active;

   assign wr_hit = ctl.wr_en && (32'(ctl.wr_chan) == CELL_IDX);
   assign active = (CELL_IDX < 32'(chans));

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_en && active) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         w_ff <= mem[rd_addr];
      end
      if (ctl.mac_en) begin
         prod_ff <= PROD_W'(ctl.val * w_ff);
      end
      if (ctl.capture) begin
         chain_ff <= acc_in;
      end else if (ctl.shift) begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.capture) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign chain_out = chain_ff;

endmodule
